FILE: hdl/fpsc_pkg.sv
// shared widths and constants of the fixed-point sine and cosine unit
package fpsc_pkg;

   localparam int ANGLE_W = 24;  // input angle, Q20 radians
   localparam int TURN_W  = 25;  // folded angle with headroom for the fold
   localparam int OUT_W   = 12;  // result, Q10

   localparam logic signed [TURN_W-1:0] HALF_TURN    = 25'sd3294206;
   localparam logic signed [TURN_W-1:0] FULL_TURN    = 25'sd6588413;
   localparam logic signed [TURN_W-1:0] QUARTER_TURN = 25'sd1647100;

   localparam logic signed [11:0] LIN_COEF  = 12'sd1304;
   localparam logic signed [9:0]  SQ_COEF   = 10'sd415;
   localparam logic signed [9:0]  CORR_COEF = 10'sd261;

endpackage

FILE: hdl/fpsc_sine.sv
// seven-stage pipelined parabolic sine with precision correction
module fpsc_sine (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  logic signed [fpsc_pkg::TURN_W-1:0]   in_angle,
   output logic                                 out_valid,
   output logic signed [fpsc_pkg::OUT_W-1:0]    out_value
);

   localparam int NSTAGE = 7;

   logic [NSTAGE-1:0] valid_ff;

   // stage 1
   logic signed [12:0] x1_ff;
   logic               neg1_ff;
   // stage 2
   logic signed [12:0] x2_ff;
   logic               neg2_ff;
   logic signed [21:0] m2_ff;
   logic signed [24:0] lin2_ff;
   // stage 3
   logic               neg3_ff;
   logic signed [24:0] sq3_ff;
   logic signed [24:0] lin3_ff;
   // stage 4
   logic signed [25:0] y4_ff;
   // stage 5
   logic signed [32:0] prod5_ff;
   logic signed [25:0] y5_ff;
   // stage 6
   logic signed [32:0] corr6_ff;
   logic signed [25:0] y6_ff;
   // stage 7
   logic signed [fpsc_pkg::OUT_W-1:0] out7_ff;

   logic signed [21:0] m2_in;
   logic signed [24:0] lin2_in;
   logic signed [11:0] mh;
   logic signed [24:0] sq3_in;
   logic signed [25:0] y4_in;
   logic signed [15:0] yh;
   logic signed [26:0] y_ext;
   logic signed [26:0] y_neg;
   logic signed [26:0] y_mag;
   logic signed [16:0] ya;
   logic signed [32:0] prod5_in;
   logic signed [32:0] diff;
   logic signed [22:0] d_sh;
   logic signed [32:0] corr6_in;
   logic signed [32:0] sum;
   logic signed [fpsc_pkg::OUT_W-1:0] out7_in;

   always_comb begin
      m2_in   = 22'(x1_ff) * 22'(fpsc_pkg::SQ_COEF);
      lin2_in = 25'(x1_ff) * 25'(fpsc_pkg::LIN_COEF);

      // floor(415x / 2^10) times x
      mh     = m2_ff[21:10];
      sq3_in = 25'(mh) * 25'(x2_ff);

      // sign of the angle picks the sign of the square term
      if (neg3_ff) begin
         y4_in = 26'(lin3_ff) + 26'(sq3_ff);
      end else begin
         y4_in = 26'(lin3_ff) - 26'(sq3_ff);
      end

      yh    = y4_ff[25:10];
      y_ext = 27'(y4_ff);
      y_neg = 27'sd0 - y_ext;
      y_mag = y4_ff[25] ? y_neg : y_ext;
      ya    = y_mag[26:10];
      prod5_in = 33'(yh) * 33'(ya);

      diff     = prod5_ff - 33'(y5_ff);
      d_sh     = diff[32:10];
      corr6_in = 33'(d_sh) * 33'(fpsc_pkg::CORR_COEF);

      sum     = corr6_ff + 33'(y6_ff);
      out7_in = sum[10 +: fpsc_pkg::OUT_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[NSTAGE-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      x1_ff    <= in_angle[22:10];
      neg1_ff  <= in_angle[fpsc_pkg::TURN_W-1];
      x2_ff    <= x1_ff;
      neg2_ff  <= neg1_ff;
      m2_ff    <= m2_in;
      lin2_ff  <= lin2_in;
      neg3_ff  <= neg2_ff;
      sq3_ff   <= sq3_in;
      lin3_ff  <= lin2_ff;
      y4_ff    <= y4_in;
      prod5_ff <= prod5_in;
      y5_ff    <= y4_ff;
      corr6_ff <= corr6_in;
      y6_ff    <= y5_ff;
      out7_ff  <= out7_in;
   end

   assign out_valid = valid_ff[NSTAGE-1];
   assign out_value = out7_ff;

endmodule

FILE: hdl/fixed_point_sine_cosine.sv
// top level: angle fold, quarter-turn offset and two sine pipelines
// throughput: one angle per cycle while busy is low; two fold stages then seven stages per sine pipeline
// rsp_valid strobes for one cycle per result; the receiver cannot stall, so nothing waits
// reset: synchronous, clears all valid bits; busy is high in reset and for the cycle after reset
// and low otherwise, so start is taken in every cycle in which busy is low
module fixed_point_sine_cosine (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [fpsc_pkg::ANGLE_W-1:0]  req_angle,
   output logic                                 rsp_valid,
   output logic signed [fpsc_pkg::OUT_W-1:0]    rsp_sine,
   output logic signed [fpsc_pkg::OUT_W-1:0]    rsp_cosine
);

   logic busy_ff;
   logic v1_ff;
   logic v2_ff;
   logic signed [fpsc_pkg::TURN_W-1:0] t1_ff;
   logic signed [fpsc_pkg::TURN_W-1:0] t2_ff;
   logic signed [fpsc_pkg::TURN_W-1:0] c2_ff;

   logic signed [fpsc_pkg::TURN_W-1:0] a_ext;
   logic signed [fpsc_pkg::TURN_W-1:0] t1_in;
   logic signed [fpsc_pkg::TURN_W-1:0] c_sum;
   logic signed [fpsc_pkg::TURN_W-1:0] c2_in;
   logic                               accept;
   logic                               s_valid;
   logic                               c_valid;

   assign accept = start & ~busy_ff;

   always_comb begin
      // one fold into about plus or minus pi
      a_ext = fpsc_pkg::TURN_W'(req_angle);
      if (a_ext > fpsc_pkg::HALF_TURN) begin
         t1_in = a_ext - fpsc_pkg::FULL_TURN;
      end else if (a_ext < -fpsc_pkg::HALF_TURN) begin
         t1_in = a_ext + fpsc_pkg::FULL_TURN;
      end else begin
         t1_in = a_ext;
      end

      // cosine path: shift by a quarter turn, fold down once
      c_sum = t1_ff + fpsc_pkg::QUARTER_TURN;
      if (c_sum > fpsc_pkg::HALF_TURN) begin
         c2_in = c_sum - fpsc_pkg::FULL_TURN;
      end else begin
         c2_in = c_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
      end else begin
         busy_ff <= 1'b0;
         v1_ff   <= accept;
         v2_ff   <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      t1_ff <= t1_in;
      t2_ff <= t1_ff;
      c2_ff <= c2_in;
   end

   fpsc_sine u_sine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v2_ff),
      .in_angle  (t2_ff),
      .out_valid (s_valid),
      .out_value (rsp_sine)
   );

   fpsc_sine u_cosine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v2_ff),
      .in_angle  (c2_ff),
      .out_valid (c_valid),
      .out_value (rsp_cosine)
   );

   assign busy      = busy_ff;
   assign rsp_valid = s_valid & c_valid;

endmodule

FILE: sim/tb_top.sv
// self-checking testbench for the fixed-point sine and cosine unit
`timescale 1ns / 1ps

module tb_top;

   localparam longint WRAP_LIMIT  = 3294206;
   localparam longint TWO_PI      = 6588413;
   localparam longint HALF_PI     = 1647100;
   localparam int     RANDOM_BEATS = 1800;
   localparam int     MAX_GAP     = 17;
   localparam int     DRAIN_CYCLES = 12;

   typedef struct packed {
      logic signed [fpsc_pkg::OUT_W-1:0] sine;
      logic signed [fpsc_pkg::OUT_W-1:0] cosine;
   } trig_pair_type;

   typedef struct {
      logic signed [fpsc_pkg::ANGLE_W-1:0] angle;
      bit                                  known;
      trig_pair_type                       pair;
   } angle_row_type;

   logic                                clock;
   logic                                reset;
   logic                                start;
   logic                                busy;
   logic signed [fpsc_pkg::ANGLE_W-1:0] req_angle;
   logic                                rsp_valid;
   logic signed [fpsc_pkg::OUT_W-1:0]   rsp_sine;
   logic signed [fpsc_pkg::OUT_W-1:0]   rsp_cosine;

   trig_pair_type pending_trig_q[$];
   int            err_count;
   bit            burst_mode;

   fixed_point_sine_cosine dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_angle  (req_angle),
      .rsp_valid  (rsp_valid),
      .rsp_sine   (rsp_sine),
      .rsp_cosine (rsp_cosine)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("fixed_point_sine_cosine regression: fail");
      $finish;
   end

   // parabola plus precision correction, every shift a floor
   function automatic longint parabola_q10(longint t);
      longint x, sq, y, prod;
      x  = t >>> 10;
      sq = ((415 * x) >>> 10) * x;
      y  = (t < 0) ? (1304 * x + sq) : (1304 * x - sq);
      if (y < 0)
         prod = (y >>> 10) * ((-y) >>> 10);
      else
         prod = (y >>> 10) * (y >>> 10);
      y = 261 * ((prod - y) >>> 10) + y;
      return y >>> 10;
   endfunction

   function automatic trig_pair_type predict_trig(logic signed [fpsc_pkg::ANGLE_W-1:0] angle);
      longint        t, c, s_val, c_val;
      trig_pair_type r;
      t = angle;
      if (t > WRAP_LIMIT)
         t = t - TWO_PI;
      else if (t < -WRAP_LIMIT)
         t = t + TWO_PI;
      c = t + HALF_PI;
      if (c > WRAP_LIMIT)
         c = c - TWO_PI;
      s_val    = parabola_q10(t);
      c_val    = parabola_q10(c);
      r.sine   = s_val[fpsc_pkg::OUT_W-1:0];
      r.cosine = c_val[fpsc_pkg::OUT_W-1:0];
      return r;
   endfunction

   function automatic logic signed [fpsc_pkg::ANGLE_W-1:0] random_angle();
      int     kind;
      longint base;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1, 2, 3: begin
            return fpsc_pkg::ANGLE_W'($urandom());
         end
         4, 5: begin
            return fpsc_pkg::ANGLE_W'(int'($urandom_range(0, 2 * TWO_PI)) - int'(TWO_PI));
         end
         6: begin
            case ($urandom_range(0, 5))
               0: base = WRAP_LIMIT;
               1: base = -WRAP_LIMIT;
               2: base = TWO_PI;
               3: base = -TWO_PI;
               4: base = WRAP_LIMIT - HALF_PI;
               default: base = -HALF_PI;
            endcase
            return fpsc_pkg::ANGLE_W'(base + int'($urandom_range(0, 16)) - 8);
         end
         7: begin
            return fpsc_pkg::ANGLE_W'(int'($urandom_range(0, 8191)) - 4096);
         end
         default: begin
            return fpsc_pkg::ANGLE_W'(int'($urandom_range(0, 2 * WRAP_LIMIT)) -
                                      int'(WRAP_LIMIT));
         end
      endcase
   endfunction

   // hold one beat on the request ports until it is taken, then log its result
   task automatic send_angle(logic signed [fpsc_pkg::ANGLE_W-1:0] angle, bit known,
                             trig_pair_type typed);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start     <= 1'b1;
      req_angle <= angle;
      do @(posedge clock); while (busy);
      pending_trig_q.push_back(known ? typed : predict_trig(angle));
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_trig_q.size() != 0) @(posedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      trig_pair_type want;
      if (!reset && rsp_valid) begin
         if (pending_trig_q.size() == 0) begin
            err_count = err_count + 1;
            if (err_count <= 10)
               $display("unexpected result beat: sine %0d cosine %0d", rsp_sine, rsp_cosine);
         end else begin
            want = pending_trig_q.pop_front();
            if (rsp_sine !== want.sine || rsp_cosine !== want.cosine) begin
               err_count = err_count + 1;
               if (err_count <= 10)
                  $display("mismatch: sine exp %0d got %0d, cosine exp %0d got %0d",
                           want.sine, rsp_sine, want.cosine, rsp_cosine);
            end
         end
      end
   end

   initial begin
      angle_row_type directed[$];
      angle_row_type row;
      trig_pair_type none;
      int            limit;

      none       = '0;
      err_count  = 0;
      burst_mode = 1'b0;
      reset      = 1'b1;
      start      = 1'b0;
      req_angle  = '0;

      // zero angle reads straight off the parabola
      directed.push_back('{24'sd0, 1'b1, '{12'sd0, 12'sd1025}});
      directed.push_back('{24'sh7FFFFF, 1'b0, none});
      directed.push_back('{24'sh800000, 1'b0, none});
      directed.push_back('{24'sd6588413, 1'b0, none});
      directed.push_back('{-24'sd6588413, 1'b0, none});
      directed.push_back('{24'sd3294206, 1'b0, none});
      directed.push_back('{24'sd3294207, 1'b0, none});
      directed.push_back('{-24'sd3294206, 1'b0, none});
      directed.push_back('{-24'sd3294207, 1'b0, none});
      directed.push_back('{24'sd1647100, 1'b0, none});
      directed.push_back('{-24'sd1647100, 1'b0, none});
      // cosine path folds again just above this angle
      directed.push_back('{24'sd1647106, 1'b0, none});
      directed.push_back('{24'sd1647107, 1'b0, none});
      directed.push_back('{24'sd1, 1'b0, none});
      directed.push_back('{-24'sd1, 1'b0, none});
      directed.push_back('{24'sd1023, 1'b0, none});
      directed.push_back('{24'sd1024, 1'b0, none});
      directed.push_back('{-24'sd1024, 1'b0, none});
      directed.push_back('{-24'sd1025, 1'b0, none});
      directed.push_back('{24'sd4941310, 1'b0, none});
      directed.push_back('{-24'sd4941310, 1'b0, none});
      directed.push_back('{24'sh555555, 1'b0, none});
      directed.push_back('{24'shAAAAAA, 1'b0, none});

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         row = directed[i];
         send_angle(row.angle, row.known, row.pair);
      end
      drain_results();

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 64 == 0)
            burst_mode = ($urandom_range(0, 3) == 0);
         if (n == RANDOM_BEATS / 2)
            drain_results();
         send_angle(random_angle(), 1'b0, none);
      end

      start <= 1'b0;
      limit = 0;
      while (pending_trig_q.size() != 0 && limit < 1000) begin
         @(posedge clock);
         limit = limit + 1;
      end
      if (pending_trig_q.size() != 0)
         err_count = err_count + pending_trig_q.size();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (err_count == 0)
         $display("fixed_point_sine_cosine regression: pass");
      else
         $display("fixed_point_sine_cosine regression: fail");
      $finish;
   end

endmodule
